@@ rtl/urwl_pkg.sv @@
// Package for the upload rate window limiter.
// Holds field widths, history depth, event kinds and the controller-datapath types.
// Used by every other file of the block but urwl_rsp_if and urwl_checker.
`timescale 1ns / 1ps
`default_nettype none

package urwl_pkg;

	localparam int HISTORY_DEPTH = 10;
	localparam int IDX_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

	localparam int TIME_W  = 48;
	localparam int BYTES_W = 24;
	localparam int LIMIT_W = 17;
	localparam int LIM_W   = LIMIT_W - 1;
	localparam int PEER_W  = 10;
	localparam int SUM_W   = BYTES_W + $clog2(HISTORY_DEPTH + 1);

	localparam int MUL_W    = 32;
	localparam int PROD_W   = LIM_W + MUL_W;
	localparam int KB_SHIFT = 10;
	localparam int MS_W     = 10;
	localparam int SUMK_W   = SUM_W + MS_W;
	localparam int CMP_W    = PROD_W + KB_SHIFT;

	localparam logic [PEER_W-1:0] PEERS_MAX = {PEER_W{1'b1}};
	localparam logic [MS_W-1:0]   MS_PER_S  = MS_W'(1000);
	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(HISTORY_DEPTH - 1);

	typedef enum logic [1:0] {
		KIND_QUERY    = 2'd0,
		KIND_CHOKED   = 2'd1,
		KIND_UNCHOKED = 2'd2,
		KIND_UPLOADED = 2'd3
	} kind_t;

	typedef struct packed {
		logic             accept;
		logic             issue;
		logic [IDX_W-1:0] idx;
		logic             finish;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/urwl_req_if.sv @@
// Request channel of the upload rate window limiter: one event with its time.
// Depends on urwl_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface urwl_req_if;
	import urwl_pkg::*;

	logic                valid;
	logic                ready;
	kind_t               kind;
	logic [TIME_W-1:0]   now_ms;
	logic [BYTES_W-1:0]  upload_bytes;

	modport source (output valid, output kind, output now_ms, output upload_bytes, input ready);
	modport sink   (input valid, input kind, input now_ms, input upload_bytes, output ready);
endinterface

`default_nettype wire

@@ rtl/urwl_rsp_if.sv @@
// Response channel of the upload rate window limiter: the two permission flags.
// Uses nothing from urwl_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface urwl_rsp_if;
	logic valid;
	logic ready;
	logic may_unchoke;
	logic may_upload;

	modport source (output valid, output may_unchoke, output may_upload, input ready);
	modport sink   (input valid, input may_unchoke, input may_upload, output ready);
endinterface

`default_nettype wire

@@ rtl/urwl_datapath.sv @@
// Datapath: limit register, peer count, upload history, budget multiply-compare
// and the response register. Driven by urwl_ctrl through urwl_pkg::dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module urwl_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic signed [urwl_pkg::LIMIT_W-1:0] cfg_wdata,
	input  urwl_pkg::kind_t                  kind,
	input  logic [urwl_pkg::TIME_W-1:0]      now_ms,
	input  logic [urwl_pkg::BYTES_W-1:0]     upload_bytes,
	input  logic                             rsp_ready,
	output logic                             rsp_valid,
	output logic                             may_unchoke,
	output logic                             may_upload,
	input  urwl_pkg::dp_cmd_t                cmd,
	output urwl_pkg::dp_sts_t                sts
);
	import urwl_pkg::*;

	logic signed [LIMIT_W-1:0] limit_q;
	logic [PEER_W-1:0]         peers_q;
	logic [TIME_W-1:0]         hist_time_q [HISTORY_DEPTH];
	logic [BYTES_W-1:0]        hist_bytes_q [HISTORY_DEPTH];
	logic [TIME_W-1:0]         now_q;
	logic [SUM_W-1:0]          sum_q;
	logic                      hit_q;

	logic                      valid_s1;
	logic                      skip_s1;
	logic                      big_s1;
	logic [PROD_W-1:0]         prod_s1;
	logic [SUMK_W-1:0]         sumk_s1;

	logic                      rsp_valid_q;
	logic                      may_unchoke_q;
	logic                      may_upload_q;

	logic                      lim_neg;
	logic [LIM_W-1:0]          lim_mag;
	logic [TIME_W-1:0]         rd_time;
	logic [BYTES_W-1:0]        rd_bytes;
	logic [TIME_W-1:0]         el_d;
	logic [SUM_W-1:0]          sum_d;
	logic [SUMK_W-1:0]         sumk_d;
	logic [PROD_W-1:0]         prod_d;
	logic                      under_s2;
	logic [LIM_W-1:0]          slots;
	logic                      unchoke_d;

	assign lim_neg  = limit_q[LIMIT_W-1];
	assign lim_mag  = limit_q[LIM_W-1:0];
	assign rd_time  = hist_time_q[cmd.idx];
	assign rd_bytes = hist_bytes_q[cmd.idx];
	assign el_d     = (now_q > rd_time) ? (now_q - rd_time) : '0;
	assign sum_d    = sum_q + SUM_W'(rd_bytes);
	assign sumk_d   = SUMK_W'(sum_d + SUM_W'(1)) * SUMK_W'(MS_PER_S);
	assign prod_d   = PROD_W'(lim_mag) * PROD_W'(el_d[MUL_W-1:0]);
	assign under_s2 = big_s1 || (CMP_W'({prod_s1, {KB_SHIFT{1'b0}}}) >= CMP_W'(sumk_s1));
	assign slots    = LIM_W'((LIMIT_W'(lim_mag) + LIMIT_W'(1)) >> 1);
	assign unchoke_d = lim_neg || (LIM_W'(peers_q) < slots);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peers_q <= '0;
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_time_q[i]  <= '0;
				hist_bytes_q[i] <= '0;
			end
		end else if (cmd.accept) begin
			case (kind)
				KIND_CHOKED: begin
					if (peers_q != '0) begin
						peers_q <= peers_q - PEER_W'(1);
					end
				end
				KIND_UNCHOKED: begin
					if (peers_q != PEERS_MAX) begin
						peers_q <= peers_q + PEER_W'(1);
					end
				end
				KIND_UPLOADED: begin
					for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
						hist_time_q[i]  <= hist_time_q[i-1];
						hist_bytes_q[i] <= hist_bytes_q[i-1];
					end
					hist_time_q[0]  <= now_ms;
					hist_bytes_q[0] <= upload_bytes;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			now_q <= now_ms;
			sum_q <= '0;
		end else if (cmd.issue) begin
			sum_q <= sum_d;
		end
		if (cmd.issue) begin
			skip_s1 <= (lim_mag == '0) || (el_d == '0);
			big_s1  <= |el_d[TIME_W-1:MUL_W];
			prod_s1 <= prod_d;
			sumk_s1 <= sumk_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			if (cmd.accept) begin
				hit_q <= 1'b0;
			end else if (valid_s1 && !skip_s1 && under_s2) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			may_unchoke_q <= unchoke_d;
			may_upload_q  <= lim_neg || hit_q;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign may_unchoke  = may_unchoke_q;
	assign may_upload   = may_upload_q;
	assign sts.out_free = !rsp_valid_q || rsp_ready;

endmodule

`default_nettype wire

@@ rtl/urwl_ctrl.sv @@
// Controller: sequences accept, the walk over the upload history and the result load.
// Depends on urwl_pkg; commands urwl_datapath.
`timescale 1ns / 1ps
`default_nettype none

module urwl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output urwl_pkg::dp_cmd_t cmd,
	input  urwl_pkg::dp_sts_t sts
);
	import urwl_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_WALK  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t           state_q;
	state_t           state_d;
	logic [IDX_W-1:0] idx_q;

	assign req_ready  = (state_q == ST_IDLE);
	assign cmd.accept = req_valid && req_ready;
	assign cmd.issue  = (state_q == ST_WALK);
	assign cmd.idx    = idx_q;
	assign cmd.finish = (state_q == ST_DONE) && sts.out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (idx_q == LAST_IDX) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.accept) begin
				idx_q <= '0;
			end else if (cmd.issue && idx_q != LAST_IDX) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/upload_rate_window_limiter.sv @@
// Top level of the upload rate window limiter.
// Joins urwl_ctrl and urwl_datapath; uses urwl_pkg, urwl_req_if and urwl_rsp_if.
//
// Usage: each request on req carries an event kind (query, peer choked, peer
// unchoked, bytes uploaded), a millisecond time and a byte count. The event is
// applied to the peer count or to the ten-entry upload history, and one response
// with may_unchoke and may_upload follows on rsp for every request, in order.
// The user writes the signed limit in KB/s through cfg_we and cfg_wdata only
// while the block is idle (the block does not enforce it); a negative limit sets both flags.
// One request is in work at a time: req.ready is low from the accept until the
// result is loaded into the output register. The work is a walk over the ten
// history entries through one shared multiply and compare, one entry per cycle,
// then a drain state for the last compare, and then the result load.
// A finished response waits in an output register; the next request is taken
// while it waits, and the controller holds a second result until rsp.ready.
// Reset (arst_n low) clears the limit, the peer count, the history and the
// response valid flag; req.ready is high in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module upload_rate_window_limiter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic signed [urwl_pkg::LIMIT_W-1:0] cfg_wdata,
	urwl_req_if.sink                         req,
	urwl_rsp_if.source                       rsp
);
	import urwl_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    ready;
	logic    rsp_valid;
	logic    may_unchoke;
	logic    may_upload;

	urwl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	urwl_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.kind         (req.kind),
		.now_ms       (req.now_ms),
		.upload_bytes (req.upload_bytes),
		.rsp_ready    (rsp.ready),
		.rsp_valid    (rsp_valid),
		.may_unchoke  (may_unchoke),
		.may_upload   (may_upload),
		.cmd          (cmd),
		.sts          (sts)
	);

	assign req.ready       = ready;
	assign rsp.valid       = rsp_valid;
	assign rsp.may_unchoke = may_unchoke;
	assign rsp.may_upload  = may_upload;

endmodule

`default_nettype wire

@@ rtl/urwl_checker.sv @@
// Port-level checker for the upload rate window limiter, bound to the top level.
// Tracks requests in flight from the channel handshakes.
`timescale 1ns / 1ps
`default_nettype none

module urwl_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic may_unchoke,
	input logic may_upload
);
	logic       req_acc;
	logic       rsp_acc;
	logic [1:0] pending_q;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (req_acc && !rsp_acc) begin
			pending_q <= pending_q + 2'd1;
		end else if (rsp_acc && !req_acc) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req_ready)
		else $error("request taken while the previous one is still in work");

	a_no_orphan_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 2'd0)
		else $error("response shown with no request outstanding");

	a_bounded_pending: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two requests outstanding");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(may_unchoke) && $stable(may_upload))
		else $error("stalled response changed");

endmodule

bind upload_rate_window_limiter urwl_checker u_urwl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.may_unchoke (rsp.may_unchoke),
	.may_upload  (rsp.may_upload)
);

`default_nettype wire

@@ test/tb.sv @@
// Testbench for upload_rate_window_limiter: a table of directed events, then random
// phases under several limits, checked against table values or an in-bench model.
// Depends on urwl_pkg, urwl_req_if, urwl_rsp_if and the RTL of the block.
`timescale 1ns / 1ps

module tb;
	import urwl_pkg::*;

	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int N_ROWS         = 22;
	localparam int N_PHASES       = 9;
	localparam int PHASE_ITEMS    = 25;
	localparam int TOP_ITEMS      = 40;
	localparam logic [TIME_W-1:0]  TMAX = {TIME_W{1'b1}};
	localparam logic [BYTES_W-1:0] BMAX = {BYTES_W{1'b1}};

	typedef struct packed {
		logic unchoke;
		logic upload;
	} flags_t;

	typedef struct packed {
		logic                      wr;
		logic signed [LIMIT_W-1:0] lim;
		kind_t                     kind;
		logic [TIME_W-1:0]         now;
		logic [BYTES_W-1:0]        nbytes;
		logic                      typed;
		flags_t                    want;
	} stim_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we;
	logic signed [LIMIT_W-1:0] cfg_wdata;

	urwl_req_if req_if();
	urwl_rsp_if rsp_if();

	upload_rate_window_limiter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req_if),
		.rsp(rsp_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic signed [LIMIT_W-1:0] lim_kbps;
	logic [PEER_W-1:0]         peer_cnt;
	logic [TIME_W-1:0]         up_time [HISTORY_DEPTH];
	logic [BYTES_W-1:0]        up_bytes [HISTORY_DEPTH];

	flags_t    flags_due [$];
	stim_row_t plan [N_ROWS];
	int        mismatches = 0;
	int        events_taken = 0;
	int        burst_left = 0;
	int        quiet = 0;

	function automatic flags_t apply_event(kind_t k, logic [TIME_W-1:0] now,
			logic [BYTES_W-1:0] nb);
		flags_t             f;
		logic [LIMIT_W-1:0] lim_u;
		logic [LIMIT_W:0]   half;
		logic [TIME_W-1:0]  el;
		logic [127:0]       sum;
		logic [127:0]       budget;
		case (k)
			KIND_CHOKED: begin
				if (peer_cnt != '0)
					peer_cnt = peer_cnt - 1'b1;
			end
			KIND_UNCHOKED: begin
				if (peer_cnt != PEERS_MAX)
					peer_cnt = peer_cnt + 1'b1;
			end
			KIND_UPLOADED: begin
				for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
					up_time[i]  = up_time[i-1];
					up_bytes[i] = up_bytes[i-1];
				end
				up_time[0]  = now;
				up_bytes[0] = nb;
			end
			default: ;
		endcase
		f = 2'b11;
		if (!lim_kbps[LIMIT_W-1]) begin
			lim_u     = lim_kbps;
			half      = ({1'b0, lim_u} + 1'b1) >> 1;
			f.unchoke = {{(LIMIT_W + 1 - PEER_W){1'b0}}, peer_cnt} < half;
			f.upload  = 1'b0;
			sum       = '0;
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				el     = (now > up_time[i]) ? now - up_time[i] : '0;
				sum    = sum + up_bytes[i];
				budget = 128'(lim_u) * 128'(el) * 128'd1024;
				if (lim_u != '0 && el != '0 && (sum + 1) * 128'd1000 <= budget)
					f.upload = 1'b1;
			end
		end
		return f;
	endfunction

	task automatic send_event(input kind_t k, input logic [TIME_W-1:0] now,
			input logic [BYTES_W-1:0] nb, input logic typed, input flags_t want);
		int     gap;
		flags_t got;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if ($urandom_range(0, 19) == 0)
				gap = 60;
			if (gap > 0) begin
				req_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_if.valid        <= 1'b1;
		req_if.kind         <= k;
		req_if.now_ms       <= now;
		req_if.upload_bytes <= nb;
		do @(posedge clk); while (!req_if.ready);
		events_taken++;
		got = apply_event(k, now, nb);
		flags_due.push_back(typed ? want : got);
	endtask

	task automatic set_limit(input logic signed [LIMIT_W-1:0] v);
		req_if.valid <= 1'b0;
		while (flags_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		lim_kbps = v;
	endtask

	initial begin
		kind_t                     k;
		logic [TIME_W-1:0]         cur_ms;
		logic [BYTES_W-1:0]        nb;
		logic signed [LIMIT_W-1:0] lim_next;
		int                        r;
		int                        span;
		int                        n;
		int                        top_items;
		bit                        fill;
		bit                        reached;
		req_if.valid        <= 1'b0;
		req_if.kind         <= KIND_QUERY;
		req_if.now_ms       <= '0;
		req_if.upload_bytes <= '0;
		cfg_we              <= 1'b0;
		cfg_wdata           <= '0;
		lim_kbps = '0;
		peer_cnt = '0;
		for (int i = 0; i < HISTORY_DEPTH; i++) begin
			up_time[i]  = '0;
			up_bytes[i] = '0;
		end
		plan = '{
			'{1'b0, 17'sd0,     KIND_QUERY,    48'd0,    24'd0,    1'b1, 2'b00},
			'{1'b0, 17'sd0,     KIND_CHOKED,   48'd5,    24'd0,    1'b1, 2'b00},
			'{1'b0, 17'sd0,     KIND_UPLOADED, TMAX,     BMAX,     1'b1, 2'b00},
			'{1'b0, 17'sd0,     KIND_UNCHOKED, TMAX,     24'd0,    1'b1, 2'b00},
			'{1'b1, -17'sd1,    KIND_QUERY,    48'd0,    24'd0,    1'b1, 2'b11},
			'{1'b0, 17'sd0,     KIND_UPLOADED, 48'd100,  24'd0,    1'b1, 2'b11},
			'{1'b0, 17'sd0,     KIND_CHOKED,   48'd100,  24'd0,    1'b1, 2'b11},
			'{1'b0, 17'sd0,     KIND_UNCHOKED, 48'd200,  24'd0,    1'b1, 2'b11},
			'{1'b1, 17'sd65535, KIND_QUERY,    48'd1000, 24'd0,    1'b0, 2'b00},
			'{1'b0, 17'sd0,     KIND_UPLOADED, 48'd1000, BMAX,     1'b0, 2'b00},
			'{1'b0, 17'sd0,     KIND_QUERY,    TMAX,     24'd0,    1'b0, 2'b00},
			'{1'b1, 17'sd1000,  KIND_UPLOADED, 48'd5000, 24'd1023, 1'b0, 2'b00},
			'{1'b0, 17'sd0,     KIND_QUERY,    48'd5001, 24'd0,    1'b0, 2'b00},
			'{1'b0, 17'sd0,     KIND_UPLOADED, 48'd5001, 24'd1,    1'b0, 2'b00},
			'{1'b0, 17'sd0,     KIND_QUERY,    48'd5002, 24'd0,    1'b0, 2'b00},
			'{1'b0, 17'sd0,     KIND_QUERY,    48'd4000, 24'd0,    1'b0, 2'b00},
			'{1'b1, 17'sd1,     KIND_CHOKED,   48'd6000, 24'd0,    1'b0, 2'b00},
			'{1'b0, 17'sd0,     KIND_UNCHOKED, 48'd6000, 24'd0,    1'b0, 2'b00},
			'{1'b1, 17'sd2,     KIND_QUERY,    48'd6000, 24'd0,    1'b0, 2'b00},
			'{1'b0, 17'sd0,     KIND_UPLOADED, 48'd7000, 24'd0,    1'b0, 2'b00},
			'{1'b1, 17'sd0,     KIND_QUERY,    48'd8000, 24'd0,    1'b1, 2'b00},
			'{1'b0, 17'sd0,     KIND_UPLOADED, 48'd9000, BMAX,     1'b1, 2'b00}
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].wr)
				set_limit(plan[i].lim);
			send_event(plan[i].kind, plan[i].now, plan[i].nbytes, plan[i].typed,
				plan[i].want);
		end

		cur_ms = 48'd9000;
		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0: lim_next = 17'sd1000;
				1: lim_next = 17'sd3;
				2: lim_next = 17'sd65535;
				3: lim_next = -17'sd1;
				4: lim_next = LIMIT_W'($urandom_range(1, 65535));
				5: lim_next = 17'sd0;
				6: lim_next = LIMIT_W'($urandom_range(1, 64));
				7: lim_next = 17'sd2045;
				default: lim_next = LIMIT_W'($urandom_range(100, 5000));
			endcase
			set_limit(lim_next);
			// The fill phase drives the peer count to its ceiling and then works around it.
			fill      = (p == 7);
			reached   = 1'b0;
			top_items = 0;
			n         = 0;
			while (fill ? top_items < TOP_ITEMS : n < PHASE_ITEMS) begin
				n++;
				r = $urandom_range(0, 99);
				if (fill && !reached)
					k = (r < 92) ? KIND_UNCHOKED : (r < 98) ? KIND_UPLOADED : KIND_QUERY;
				else if (fill)
					k = (r < 45) ? KIND_UNCHOKED : (r < 80) ? KIND_CHOKED :
						(r < 90) ? KIND_UPLOADED : KIND_QUERY;
				else
					k = (r < 15) ? KIND_QUERY : (r < 35) ? KIND_CHOKED :
						(r < 60) ? KIND_UNCHOKED : KIND_UPLOADED;

				r = $urandom_range(0, 99);
				if (r < 20)
					cur_ms = cur_ms;
				else if (r < 60)
					cur_ms = cur_ms + $urandom_range(1, 20);
				else if (r < 85)
					cur_ms = cur_ms + $urandom_range(21, 1000);
				else if (r < 93)
					cur_ms = cur_ms + $urandom_range(1001, 100000);
				else if (r < 97)
					cur_ms = cur_ms - $urandom_range(1, 500);
				else if (r < 99)
					cur_ms = TIME_W'({$urandom, $urandom});
				else
					cur_ms = cur_ms + (TIME_W'(1) << 32) + $urandom;

				span = (lim_kbps < 0) ? 40000 : lim_kbps * 40 + 1;
				if (span > int'(BMAX))
					span = int'(BMAX);
				r = $urandom_range(0, 99);
				if (r < 10)
					nb = '0;
				else if (r < 15)
					nb = BMAX;
				else if (r < 30)
					nb = BYTES_W'($urandom);
				else
					nb = BYTES_W'($urandom_range(0, span));

				send_event(k, cur_ms, nb, 1'b0, 2'b00);
				if (fill && peer_cnt == PEERS_MAX)
					reached = 1'b1;
				if (reached)
					top_items++;
			end
		end

		req_if.valid <= 1'b0;
		while (flags_due.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// The receiver mixes free-running, patterned and random stalls, and twice holds off
	// long enough that the block fills and stops taking requests.
	initial begin
		int mode;
		int left;
		int hold;
		int holds_done;
		int rx_cycle;
		mode       = 0;
		left       = 0;
		hold       = 0;
		holds_done = 0;
		rx_cycle   = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (hold > 0) begin
				hold--;
				rsp_if.ready <= 1'b0;
			end else if (holds_done < 2 && events_taken >= (holds_done + 1) * 500) begin
				hold = LONG_HOLD;
				holds_done++;
				rsp_if.ready <= 1'b0;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(30, 300);
				end
				left--;
				case (mode)
					0: rsp_if.ready <= 1'b1;
					1: rsp_if.ready <= (rx_cycle % 8) < 5;
					2: rsp_if.ready <= $urandom_range(0, 1);
					default: rsp_if.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		flags_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (flags_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected response may_unchoke=%b may_upload=%b",
					$time, rsp_if.may_unchoke, rsp_if.may_upload);
			end else begin
				want = flags_due.pop_front();
				if (rsp_if.may_unchoke !== want.unchoke) begin
					mismatches++;
					$display("%0t: may_unchoke expected %b actual %b",
						$time, want.unchoke, rsp_if.may_unchoke);
				end
				if (rsp_if.may_upload !== want.upload) begin
					mismatches++;
					$display("%0t: may_upload expected %b actual %b",
						$time, want.upload, rsp_if.may_upload);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

endmodule

@@ sim.f @@
rtl/urwl_pkg.sv
rtl/urwl_req_if.sv
rtl/urwl_rsp_if.sv
rtl/urwl_datapath.sv
rtl/urwl_ctrl.sv
rtl/upload_rate_window_limiter.sv
rtl/urwl_checker.sv
test/tb.sv
